// ===== src/gha_pkg.sv =====
package gha_pkg;

   localparam int BlockWidth     = 128;
   localparam int HalfWidth      = 64;
   localparam int CountWidth     = 5;
   localparam int BlockBytes     = 16;
   localparam int ReqDataWidth   = 136;
   localparam int RspDataWidth   = 128;
   localparam int CsrIndexWidth  = 2;
   localparam int CsrDataWidth   = 64;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_SUBKEY_HI = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SUBKEY_LO = 2'd1;

   // reduction constant for the bit-reflected field: 0xE1 in the top byte
   localparam logic [BlockWidth-1:0] GhashPoly = {8'hE1, 120'd0};

   typedef struct packed {
      logic [BlockWidth-1:0] block;    // masked block, byte 0 in the top bits
      logic                  absorb;   // byte count was nonzero
      logic                  restart;
   } gha_item_type;

   typedef struct packed {
      logic         valid;
      gha_item_type item;
   } gha_q_stat_type;

   // Bit-reflected GF(2^128) product; bit 127 of each operand is the x^0 term.
   function automatic logic [BlockWidth-1:0] gf128_mul(
      input logic [BlockWidth-1:0] x,
      input logic [BlockWidth-1:0] y
   );
      logic [BlockWidth-1:0] acc;
      logic [BlockWidth-1:0] v;
      acc = '0;
      v   = y;
      for (int i = 0; i < BlockWidth; i++) begin
         if (x[BlockWidth-1-i]) begin
            acc = acc ^ v;
         end
         if (v[0]) begin
            v = (v >> 1) ^ GhashPoly;
         end else begin
            v = v >> 1;
         end
      end
      return acc;
   endfunction

endpackage

// ===== src/ghash_accumulator_unit.sv =====
// GHASH accumulator: absorbs one 128-bit block per transfer into a running
// hash and returns the updated hash for every block.
// req channel: tdata = block_hi, block_lo, byte_count (zero-padded to 136
// bits); tuser = restart. Bytes past byte_count are taken as zero; a count
// of zero only passes the hash through (restart still clears it).
// rsp channel: tdata = digest_hi, digest_lo.
// csr channel: index 0 writes subkey_hi, index 1 subkey_lo, other indexes
// are dropped. Write the subkey only while no block is in flight.
// An accepted block is written into the queue and popped by the back stage
// once its output register is free or being drained; that register holds the digest.
// Throughput: one block per cycle while rsp accepts, set by the hash register
// loop through the combinational GF(2^128) multiplier in the back stage.
// A small queue separates the request side from the back stage, so req
// keeps taking blocks while a result waits; when rsp stalls, the queue
// fills and req_tready drops once it holds QueueDepth blocks.
// Reset clears the running hash, the subkey and the queue.
module ghash_accumulator_unit
   import gha_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ReqDataWidth-1:0]  req_tdata,  // block_hi, block_lo, byte_count, zero pad
   input  logic                     req_tuser,  // restart
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,  // digest_hi, digest_lo
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   logic [HalfWidth-1:0]  subkey_hi_ff;
   logic [HalfWidth-1:0]  subkey_lo_ff;
   gha_item_type          front_item;
   gha_q_stat_type        head;
   logic                  pop;
   logic [BlockWidth-1:0] hash_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         subkey_hi_ff <= '0;
         subkey_lo_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_SUBKEY_HI) begin
            subkey_hi_ff <= csr_data;
         end else if (csr_index == CSR_SUBKEY_LO) begin
            subkey_lo_ff <= csr_data;
         end
      end
   end

   gha_front u_front (
      .req_data (req_tdata),
      .req_flag (req_tuser),
      .item     (front_item)
   );

   gha_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (front_item),
      .head       (head),
      .pop        (pop)
   );

   gha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .subkey    ({subkey_hi_ff, subkey_lo_ff}),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hash  (hash_out)
   );

   assign rsp_tdata = {hash_out[HalfWidth-1:0], hash_out[BlockWidth-1:HalfWidth]};

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("back stage popped an empty queue");

   a_result_follows_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pop))
      else $error("result raised without a queue transfer");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head.item.restart && !head.item.absorb) |=> (rsp_tdata == '0))
      else $error("restart without data did not clear the hash");

endmodule

// ===== src/gha_front.sv =====
module gha_front
   import gha_pkg::*;
(
   input  logic [ReqDataWidth-1:0] req_data,
   input  logic                    req_flag,
   output gha_item_type            item
);

   logic [HalfWidth-1:0]  block_hi;
   logic [HalfWidth-1:0]  block_lo;
   logic [CountWidth-1:0] byte_count;
   logic [CountWidth-1:0] count_sat;
   logic [BlockWidth-1:0] raw_block;
   logic [BlockWidth-1:0] keep_mask;

   assign block_hi   = req_data[HalfWidth-1:0];
   assign block_lo   = req_data[2*HalfWidth-1:HalfWidth];
   assign byte_count = req_data[2*HalfWidth+CountWidth-1:2*HalfWidth];
   assign raw_block  = {block_hi, block_lo};

   // clamp counts above sixteen to a full block
   assign count_sat = (byte_count > CountWidth'(BlockBytes)) ? CountWidth'(BlockBytes)
                                                             : byte_count;

   // keep leading bytes only; byte j sits at the top end of the word
   always_comb begin
      keep_mask = '0;
      for (int j = 0; j < BlockBytes; j++) begin
         if (CountWidth'(j) < count_sat) begin
            keep_mask[BlockWidth-1-8*j -: 8] = 8'hFF;
         end
      end
   end

   assign item.block   = raw_block & keep_mask;
   assign item.absorb  = (count_sat != '0);
   assign item.restart = req_flag;

endmodule

// ===== src/gha_queue.sv =====
module gha_queue
   import gha_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  gha_item_type   push_item,
   output gha_q_stat_type head,
   input  logic           pop
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountBits  = $clog2(Depth + 1);

   gha_item_type          entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]  count_ff, count_in;
   logic                  push;

   assign push_ready = (count_ff != CountBits'(Depth));
   assign push       = push_valid && push_ready;
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/gha_back.sv =====
module gha_back
   import gha_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  gha_q_stat_type          head,
   output logic                    pop,
   input  logic [BlockWidth-1:0]   subkey,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [BlockWidth-1:0]   out_hash
);

   logic [BlockWidth-1:0] hash_ff, hash_in;
   logic [BlockWidth-1:0] digest_ff;
   logic                  valid_ff, valid_in;
   logic [BlockWidth-1:0] base;

   // advance whenever the output register is free or being drained
   assign pop  = head.valid && (!valid_ff || out_ready);
   assign base = head.item.restart ? '0 : hash_ff;

   always_comb begin
      hash_in  = hash_ff;
      valid_in = valid_ff && !out_ready;
      if (pop) begin
         valid_in = 1'b1;
         if (head.item.absorb) begin
            hash_in = gf128_mul(base ^ head.item.block, subkey);
         end else begin
            hash_in = base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         hash_ff  <= hash_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         digest_ff <= hash_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_hash  = digest_ff;

endmodule

// ===== sim/ghash_digest_checker.sv =====
`timescale 1ns / 1ps

module ghash_digest_checker
   import gha_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [ReqDataWidth-1:0]  req_tdata,  // block_hi, block_lo, byte_count, zero pad
   input  logic                     req_tuser,  // restart
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RspDataWidth-1:0]  rsp_tdata,  // digest_hi, digest_lo
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output int                       fail_count,
   output int                       digests_due
);

   localparam logic [HalfWidth-1:0] FIELD_POLY_TOP = 64'hE100_0000_0000_0000;

   typedef struct packed {
      logic [HalfWidth-1:0] hi;
      logic [HalfWidth-1:0] lo;
   } digest_type;

   digest_type pending_digests[$];
   digest_type subkey;
   digest_type hash;
   int      mismatches = 0;
   int      due_count = 0;

   assign fail_count  = mismatches;
   assign digests_due = due_count;

   // keep the leading n bytes (0..8) of a half, top byte first
   function automatic logic [HalfWidth-1:0] lead_bytes(input logic [3:0] n);
      if (n == 0) return '0;
      if (n >= 8) return '1;
      return {HalfWidth{1'b1}} << (64 - 8 * n);
   endfunction

   // bit-reflected GF(2^128) product, MSB of hi is the x^0 term
   function automatic digest_type field_mul(input digest_type x, input digest_type y);
      digest_type acc;
      digest_type v;
      logic    bit_set;
      logic    carry;
      acc = '0;
      v   = y;
      for (int i = 0; i < 128; i++) begin
         bit_set = (i < 64) ? x.hi[63 - i] : x.lo[127 - i];
         if (bit_set) begin
            acc.hi = acc.hi ^ v.hi;
            acc.lo = acc.lo ^ v.lo;
         end
         carry = v.lo[0];
         v.lo  = {v.hi[0], v.lo[HalfWidth-1:1]};
         v.hi  = v.hi >> 1;
         if (carry) v.hi = v.hi ^ FIELD_POLY_TOP;
      end
      return acc;
   endfunction

   task automatic absorb_block(input logic [HalfWidth-1:0] bh, input logic [HalfWidth-1:0] bl,
                               input logic [CountWidth-1:0] cnt, input logic restart);
      logic [CountWidth-1:0] n;
      digest_type            sum;
      n = (cnt > BlockBytes) ? CountWidth'(BlockBytes) : cnt;
      if (restart) hash = '0;
      if (n != 0) begin
         sum.hi = hash.hi ^ (bh & lead_bytes((n > 8) ? 4'd8 : n[3:0]));
         sum.lo = hash.lo ^ (bl & lead_bytes((n > 8) ? 4'(n - 8) : 4'd0));
         hash   = field_mul(sum, subkey);
      end
      pending_digests.push_back(hash);
   endtask

   task automatic report_mismatch(input string what, input logic [HalfWidth-1:0] got,
                                  input logic [HalfWidth-1:0] want);
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      digest_type want;
      if (reset) begin
         subkey = '0;
         hash   = '0;
         pending_digests.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SUBKEY_HI: subkey.hi = csr_data;
               CSR_SUBKEY_LO: subkey.lo = csr_data;
               default: ;
            endcase
         end
         // pop before push: a digest never leaves in the cycle its block enters
         if (rsp_tvalid && rsp_tready) begin
            if (pending_digests.size() == 0) begin
               report_mismatch("digest with none due", rsp_tdata[63:0], '0);
            end else begin
               want = pending_digests.pop_front();
               if (rsp_tdata[63:0] !== want.hi)
                  report_mismatch("digest_hi", rsp_tdata[63:0], want.hi);
               if (rsp_tdata[127:64] !== want.lo)
                  report_mismatch("digest_lo", rsp_tdata[127:64], want.lo);
            end
         end
         if (req_tvalid && req_tready)
            absorb_block(req_tdata[63:0], req_tdata[127:64], req_tdata[132:128], req_tuser);
      end
      due_count = pending_digests.size();
   end

endmodule

// ===== sim/ghash_accumulator_unit_tb.sv =====
`timescale 1ns / 1ps

module ghash_accumulator_unit_tb;
   import gha_pkg::*;

   localparam int HOLD_CYCLES  = 200;
   localparam int STALL_LIMIT  = 3000;
   localparam int SETTLE       = 6;
   localparam int PHASE_ITEMS  = 120;
   localparam int RAND_PHASES  = 5;
   localparam logic [HalfWidth-1:0] ONE_HI = 64'h8000_0000_0000_0000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   int   fail_count;
   int   digests_due;
   int   quiet = 0;
   logic long_hold = 1'b0;
   logic burst = 1'b0;
   logic offering = 1'b0;

   ghash_accumulator_unit dut (.*);

   ghash_digest_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [HalfWidth-1:0] rand_half();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return ONE_HI >> $urandom_range(0, 63);
      return {$urandom, $urandom};
   endfunction

   function automatic logic [CountWidth-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return CountWidth'(BlockBytes);
      if (r < 85) return CountWidth'($urandom_range(1, 15));
      if (r < 90) return '0;
      return CountWidth'($urandom_range(17, 31));
   endfunction

   // receiver: random back-pressure, or a long hold-off on request
   initial begin
      int run;
      run = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
            rsp_tready <= 1'b1;
            run = 0;
         end else if (burst) begin
            rsp_tready <= 1'b1;
         end else if (run > 0) begin
            run--;
         end else begin
            rsp_tready <= ($urandom_range(0, 2) != 0);
            run = pick_gap();
         end
      end
   end

   // valid stays high into the next item when gap is zero
   task automatic offer_block(input logic [HalfWidth-1:0] hi, input logic [HalfWidth-1:0] lo,
                              input logic [CountWidth-1:0] cnt, input logic restart,
                              input int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataWidth - 2 * HalfWidth - CountWidth){1'b0}}, cnt, lo, hi};
      req_tuser  <= restart;
      offering = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_random(input int gap);
      offer_block(rand_half(), rand_half(), pick_count(), $urandom_range(0, 9) == 0, gap);
   endtask

   // drop valid and hold until every digest is back
   task automatic drain();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         @(negedge clock);
      end
      while (digests_due != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_subkey(input logic [HalfWidth-1:0] hi, input logic [HalfWidth-1:0] lo);
      csr_write(CSR_SUBKEY_HI, hi);
      csr_write(CSR_SUBKEY_LO, lo);
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // subkey still zero after reset: every digest is zero
      offer_block('1, '1, 5'd16, 1'b0, 1);
      drain();

      // H = 1 makes each digest the plain XOR of the padded blocks
      set_subkey(ONE_HI, '0);
      offer_block('1, '1, 5'd16, 1'b1, 0);
      offer_block('1, '1, 5'd1, 1'b0, 0);
      offer_block('1, '1, 5'd8, 1'b0, 2);
      offer_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 5'd9, 1'b0, 0);
      offer_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 5'd15, 1'b0, 0);
      offer_block('1, '1, 5'd0, 1'b0, 1);
      offer_block('1, '1, 5'd0, 1'b1, 0);
      offer_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd17, 1'b0, 0);
      offer_block('1, '1, 5'd31, 1'b0, 3);
      offer_block('0, '0, 5'd16, 1'b0, 0);
      offer_block('0, '0, 5'd16, 1'b1, 1);
      drain();

      // all-ones subkey
      set_subkey('1, '1);
      offer_block('1, '1, 5'd16, 1'b1, 0);
      offer_block('1, '1, 5'd16, 1'b0, 0);
      offer_block(64'h8000_0000_0000_0001, 64'h0000_0000_0000_0001, 5'd16, 1'b0, 0);
      offer_block(64'hDEAD_BEEF_CAFE_F00D, '1, 5'd7, 1'b0, 0);
      offer_block('1, 64'h1234_5678_9ABC_DEF0, 5'd24, 1'b0, 1);
      drain();

      // writes to unused indexes leave the subkey alone
      csr_write(2'd2, '0);
      csr_write(2'd3, '1);
      offer_block('1, '0, 5'd16, 1'b0, 0);
      offer_block('0, '1, 5'd12, 1'b0, 1);
      drain();

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         case (phase)
            0: set_subkey({$urandom, $urandom}, {$urandom, $urandom});
            1: set_subkey({$urandom, $urandom}, '1);
            2: set_subkey('0, {$urandom, $urandom});
            default: set_subkey({$urandom, $urandom}, {$urandom, $urandom});
         endcase
         burst = (phase == 2);
         if (phase == 1) begin
            // fill the queue while the receiver holds off
            long_hold = 1'b1;
            for (int k = 0; k < 30; k++) send_random(0);
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_random(burst ? 0 : pick_gap());
            if (!burst && $urandom_range(0, 49) == 0) drain();
         end
         drain();
         burst = 1'b0;
      end

      drain();
      if (fail_count == 0 && digests_due == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/gha_pkg.sv
src/gha_front.sv
src/gha_queue.sv
src/gha_back.sv
src/ghash_accumulator_unit.sv
sim/ghash_digest_checker.sv
sim/ghash_accumulator_unit_tb.sv
